// File: hw/rtl/cclp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cclp_pkg
// Shared types and codes of the cache command line parser: request and result
// words, the classified queue entry, and the command, status and class codes.
// ----------------------------------------------------------------------------
package cclp_pkg;

  // One request byte as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_request;
  } req_t;

  // One result word as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]  byte_class;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [2:0]  command_type;
    logic [30:0] duration_seconds;
  } res_t;

  // Request byte after classification by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] ucase;
    logic       end_of_request;
    logic       is_ws;
    logic       is_digit;
    logic       is_plus;
    logic       is_newline;
  } qitem_t;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_KEY   = 2'd1;
  localparam logic [1:0] CLS_VALUE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY_REQ = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_ARG_COUNT = 3'd3;
  localparam logic [2:0] ST_EMPTY_KEY = 3'd4;
  localparam logic [2:0] ST_EMPTY_VAL = 3'd5;
  localparam logic [2:0] ST_BAD_DUR   = 3'd6;

  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_GET    = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_EXISTS = 3'd3;
  localparam logic [2:0] CMD_EXPIRE = 3'd4;

  localparam int unsigned NUM_CMDS = 5;

  localparam logic [30:0] DUR_MAX = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

// File: hw/rtl/cclp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cclp_front
// Front end: accept request bytes and tag each with its character class
// (whitespace, digit, plus, newline) and an upper-cased copy for matching.
// ----------------------------------------------------------------------------
module cclp_front (
  input  wire  logic            req_valid,
  output       logic            req_ready,
  input  wire  cclp_pkg::req_t  req,
  output       logic            push,
  input  wire  logic            push_ready,
  output       cclp_pkg::qitem_t push_item
);
  import cclp_pkg::*;

  logic [7:0] c;

  assign c         = req.data_byte;
  assign req_ready = push_ready;
  assign push      = req_valid;

  always_comb begin
    push_item.data_byte      = c;
    push_item.end_of_request = req.end_of_request;
    push_item.is_ws          = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    push_item.is_digit       = (c >= "0") && (c <= "9");
    push_item.is_plus        = (c == "+");
    push_item.is_newline     = (c == 8'd10);
    // fold a..z onto A..Z
    if (c >= "a" && c <= "z") begin
      push_item.ucase = c - 8'd32;
    end else begin
      push_item.ucase = c;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cclp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cclp_queue
// Short FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module cclp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             push,
  output       logic             push_ready,
  input  wire  cclp_pkg::qitem_t push_item,
  output       logic             pop_valid,
  input  wire  logic             pop,
  output       cclp_pkg::qitem_t pop_item
);
  import cclp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qitem_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cclp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cclp_back
// Back end: parse state machine, keyword matcher and duration accumulator.
// Consume one classified byte per cycle while the output channel keeps up,
// and hold its result word in a register until the output channel takes it.
// ----------------------------------------------------------------------------
module cclp_back (
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             item_valid,
  output       logic             item_pop,
  input  wire  cclp_pkg::qitem_t item,
  output       logic             res_valid,
  input  wire  logic             res_ready,
  output       cclp_pkg::res_t   res
);
  import cclp_pkg::*;

  typedef enum logic [9:0] {
    PH_CMD_PRE = 10'b00_0000_0001,
    PH_CMD     = 10'b00_0000_0010,
    PH_KEY_PRE = 10'b00_0000_0100,
    PH_KEY     = 10'b00_0000_1000,
    PH_VAL_PRE = 10'b00_0001_0000,
    PH_VAL     = 10'b00_0010_0000,
    PH_DUR_PRE = 10'b00_0100_0000,
    PH_DUR     = 10'b00_1000_0000,
    PH_TAIL    = 10'b01_0000_0000,
    PH_IGNORE  = 10'b10_0000_0000
  } phase_t;

  localparam logic [7:0] KW_TEXT [NUM_CMDS][6] = '{
    '{"S", "E", "T", 8'd0, 8'd0, 8'd0},
    '{"G", "E", "T", 8'd0, 8'd0, 8'd0},
    '{"D", "E", "L", "E", "T", "E"},
    '{"E", "X", "I", "S", "T", "S"},
    '{"E", "X", "P", "I", "R", "E"}
  };
  localparam logic [2:0] KW_LEN [NUM_CMDS] = '{3'd3, 3'd3, 3'd6, 3'd6, 3'd6};

  phase_t        ph, ph_next, ph_end;
  logic [2:0]    idx, idx_next, idx_inc, idx_len;
  logic [4:0]    cand, cand_next, cand_end, cand_hit, cand_res;
  logic [30:0]   acc, acc_next;
  logic          ovf, ovf_next;
  logic          mal, mal_next;
  logic          dig, dig_next;
  logic          sgn, sgn_next;
  logic [2:0]    sticky, sticky_next, sticky_end;
  logic [34:0]   acc_x10;
  logic          dur_bad;
  logic          ws;
  logic          pop;
  res_t          res_next;

  // Drop candidates whose keyword disagrees at this position.
  always_comb begin
    cand_hit = cand;
    for (int k = 0; k < NUM_CMDS; k++) begin
      if (idx >= KW_LEN[k]) begin
        cand_hit[k] = 1'b0;
      end else if (KW_TEXT[k][idx] != item.ucase) begin
        cand_hit[k] = 1'b0;
      end
    end
  end

  // Hold the token index at seven once it gets there.
  assign idx_inc = (idx != 3'd7) ? idx + 3'd1 : idx;

  // Drop candidates whose length differs from the token length: the token as
  // it stands on whitespace, or as extended by this byte otherwise.
  always_comb begin
    cand_res = ws ? cand : cand_hit;
    idx_len  = ws ? idx : idx_inc;
    for (int k = 0; k < NUM_CMDS; k++) begin
      if (KW_LEN[k] != idx_len) begin
        cand_res[k] = 1'b0;
      end
    end
  end

  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, item.data_byte[3:0]};
  assign ws      = item.is_ws;
  assign pop     = item_valid && (!res_valid || res_ready);
  assign item_pop = pop;

  always_comb begin
    ph_next     = ph;
    idx_next    = idx;
    cand_next   = cand;
    acc_next    = acc;
    ovf_next    = ovf;
    mal_next    = mal;
    dig_next    = dig;
    sgn_next    = sgn;
    sticky_next = sticky;
    res_next    = '0;

    unique case (ph)
      PH_CMD_PRE, PH_CMD: begin
        if (!ws) begin
          ph_next   = PH_CMD;
          cand_next = cand_hit;
          idx_next  = idx_inc;
        end else if (ph == PH_CMD) begin
          cand_next = cand_res;
          if (cand_res == '0) begin
            sticky_next = ST_UNKNOWN;
            ph_next     = PH_IGNORE;
          end else begin
            ph_next = PH_KEY_PRE;
          end
        end
      end
      PH_KEY_PRE: begin
        if (!ws) begin
          res_next.byte_class = CLS_KEY;
          res_next.out_byte   = item.data_byte;
          ph_next             = PH_KEY;
        end
      end
      PH_KEY: begin
        if (!ws) begin
          res_next.byte_class = CLS_KEY;
          res_next.out_byte   = item.data_byte;
        end else if (cand[CMD_SET]) begin
          ph_next = PH_VAL_PRE;
        end else if (cand[CMD_EXPIRE]) begin
          ph_next = PH_DUR_PRE;
        end else begin
          ph_next = PH_TAIL;
        end
      end
      PH_VAL_PRE: begin
        if (!ws) begin
          res_next.byte_class = CLS_VALUE;
          res_next.out_byte   = item.data_byte;
          ph_next             = PH_VAL;
        end
      end
      PH_VAL: begin
        if (!item.is_newline) begin
          res_next.byte_class = CLS_VALUE;
          res_next.out_byte   = item.data_byte;
        end else begin
          ph_next = PH_IGNORE;
        end
      end
      PH_DUR_PRE, PH_DUR: begin
        if (!ws) begin
          ph_next = PH_DUR;
          if (item.is_digit) begin
            dig_next = 1'b1;
            // saturate the accumulator
            if (acc_x10 > {4'd0, DUR_MAX}) begin
              ovf_next = 1'b1;
              acc_next = DUR_MAX;
            end else begin
              acc_next = acc_x10[30:0];
            end
          end else if (item.is_plus && !dig && !sgn) begin
            sgn_next = 1'b1;
          end else begin
            mal_next = 1'b1;
          end
        end else if (ph == PH_DUR) begin
          ph_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (!ws) begin
          sticky_next = ST_ARG_COUNT;
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase

    // Close an open command token on the final byte.
    ph_end     = ph_next;
    cand_end   = cand_next;
    sticky_end = sticky_next;
    if (ph_next == PH_CMD) begin
      cand_end = cand_res;
      if (cand_res == '0) begin
        ph_end     = PH_IGNORE;
        sticky_end = ST_UNKNOWN;
      end else begin
        ph_end = PH_KEY_PRE;
      end
    end

    dur_bad = mal_next || ovf_next || !dig_next || (acc_next == '0);

    if (item.end_of_request) begin
      res_next.done_res = 1'b1;
      unique case (ph_end)
        PH_CMD_PRE: res_next.status = ST_EMPTY_REQ;
        PH_KEY_PRE: res_next.status = ST_EMPTY_KEY;
        PH_KEY: begin
          if (cand_end[CMD_SET]) begin
            res_next.status = ST_EMPTY_VAL;
          end else if (cand_end[CMD_EXPIRE]) begin
            res_next.status = ST_BAD_DUR;
          end else begin
            res_next.status = ST_OK;
          end
        end
        PH_VAL_PRE: res_next.status = ST_EMPTY_VAL;
        PH_VAL:     res_next.status = ST_OK;
        PH_DUR_PRE: res_next.status = ST_BAD_DUR;
        PH_DUR:     res_next.status = dur_bad ? ST_BAD_DUR : ST_OK;
        PH_TAIL: begin
          res_next.status = (cand_end[CMD_EXPIRE] && dur_bad) ? ST_BAD_DUR : sticky_end;
        end
        default: res_next.status = sticky_end;
      endcase

      if (res_next.status != ST_EMPTY_REQ && res_next.status != ST_UNKNOWN) begin
        if (cand_end[CMD_SET]) begin
          res_next.command_type = CMD_SET;
        end else if (cand_end[CMD_GET]) begin
          res_next.command_type = CMD_GET;
        end else if (cand_end[CMD_DELETE]) begin
          res_next.command_type = CMD_DELETE;
        end else if (cand_end[CMD_EXISTS]) begin
          res_next.command_type = CMD_EXISTS;
        end else if (cand_end[CMD_EXPIRE]) begin
          res_next.command_type = CMD_EXPIRE;
        end
      end

      if (res_next.command_type == CMD_EXPIRE && res_next.status == ST_OK) begin
        res_next.duration_seconds = acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= PH_CMD_PRE;
      idx       <= '0;
      cand      <= '1;
      acc       <= '0;
      ovf       <= 1'b0;
      mal       <= 1'b0;
      dig       <= 1'b0;
      sgn       <= 1'b0;
      sticky    <= ST_OK;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        res_valid <= 1'b1;
        if (item.end_of_request) begin
          // request closed: return to the idle parse state
          ph     <= PH_CMD_PRE;
          idx    <= '0;
          cand   <= '1;
          acc    <= '0;
          ovf    <= 1'b0;
          mal    <= 1'b0;
          dig    <= 1'b0;
          sgn    <= 1'b0;
          sticky <= ST_OK;
        end else begin
          ph     <= ph_next;
          idx    <= idx_next;
          cand   <= cand_next;
          acc    <= acc_next;
          ovf    <= ovf_next;
          mal    <= mal_next;
          dig    <= dig_next;
          sgn    <= sgn_next;
          sticky <= sticky_next;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cache_command_line_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cache_command_line_parser
// Byte-stream parser for text cache commands (SET, GET, DELETE, EXISTS,
// EXPIRE) that streams key and value bytes and reports a final status.
// ----------------------------------------------------------------------------
// Feed one request byte per word on the req channel and mark the last byte
// of each request with end_of_request. Every accepted byte yields exactly one
// result word: key and value bytes come back tagged in byte_class, and the
// word for the final byte carries done_res with status, command_type and,
// for a good EXPIRE, duration_seconds. Key and value bytes stream out before
// the request is checked, so discard them when the final status is not ok.
// The block sustains one byte per clock while the res channel takes each result
// word: the parse state machine and the duration multiply-accumulate in the
// back end update once per byte. A result passes through the queue and then
// into the back end's output register before it shows up on the res channel.
// The queue of QUEUE_DEPTH entries lets the input keep flowing while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module cache_command_line_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire  logic           clk,
  input  wire  logic           rst,
  input  wire  logic           req_valid,
  output       logic           req_ready,
  input  wire  cclp_pkg::req_t req,
  output       logic           res_valid,
  input  wire  logic           res_ready,
  output       cclp_pkg::res_t res
);
  import cclp_pkg::*;

  logic   push;
  logic   push_ready;
  qitem_t push_item;
  logic   pop_valid;
  logic   pop;
  qitem_t pop_item;

  // Classify the incoming byte on the way in.
  cclp_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple the front end from back-end stalls.
  cclp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // Advance the parser and hold each result until taken.
  cclp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_pop   (pop),
    .item       (pop_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
`default_nettype wire
